/* hw/rtl/drtim_pkg.sv */
// ----------------------------------------------------------------------------
// drtim_pkg
// Shared types and constants of the divider and reload timer.
// ----------------------------------------------------------------------------
package drtim_pkg;

  // Field widths.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned SelW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DivW   = 16;
  localparam int unsigned PreW   = 10;
  localparam int unsigned AccW   = 11;
  localparam int unsigned CntW   = 7;
  localparam int unsigned RoomW  = 9;

  // Item command codes; the fourth code is unused and does nothing.
  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd1;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd2;

  // Register select codes.
  localparam logic [SelW-1:0] REG_DIV  = 2'd0;
  localparam logic [SelW-1:0] REG_TIMA = 2'd1;
  localparam logic [SelW-1:0] REG_TMA  = 2'd2;
  localparam logic [SelW-1:0] REG_TAC  = 2'd3;

  // Rate select codes.
  localparam logic [1:0] RATE_1024 = 2'd0;
  localparam logic [1:0] RATE_16   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_256  = 2'd3;

  // Control register bit positions.
  localparam int unsigned TacEnBit = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // latch the accepted item and perform its immediate work
    logic step;   // one counter advance step of a tick
    logic push;   // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;  // no timer periods left to consume
  } dp_sts_t;

endpackage

/* hw/rtl/drtim_in_if.sv */
// ----------------------------------------------------------------------------
// drtim_in_if
// Input item channel of the timer: valid/ready with the item payload.
// ----------------------------------------------------------------------------
interface drtim_in_if;
  import drtim_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [SelW-1:0]  reg_select;
  logic [ByteW-1:0] write_data;
  logic [ByteW-1:0] cycles;

  modport source (output valid, output cmd, output reg_select, output write_data,
                  output cycles, input ready);
  modport sink   (input valid, input cmd, input reg_select, input write_data,
                  input cycles, output ready);

endinterface

/* hw/rtl/drtim_out_if.sv */
// ----------------------------------------------------------------------------
// drtim_out_if
// Result item channel of the timer: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface drtim_out_if;
  import drtim_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             overflow;

  modport source (output valid, output read_data, output overflow, input ready);
  modport sink   (input valid, input read_data, input overflow, output ready);

endinterface

/* hw/rtl/drtim_ctrl.sv */
// ----------------------------------------------------------------------------
// drtim_ctrl
// Controller: accepts items, sequences the counter steps of a tick and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module drtim_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  drtim_pkg::dp_sts_t    sts_i,
  output drtim_pkg::ctrl_cmd_t  cmd_o
);
  import drtim_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The output register can take a result when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts_i.cnt_zero) begin
          cmd_o.step = 1'b1;
        end else if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is only moved into a free output register.
  a_push_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over a waiting result");

  // An accepted item is always followed by the run state.
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_RUN))
    else $error("accepted item did not enter run state");

  // A push always leaves a valid result in the output register.
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> out_valid_q)
    else $error("pushed result not presented");

endmodule

/* hw/rtl/drtim_dp.sv */
// ----------------------------------------------------------------------------
// drtim_dp
// Datapath: timer registers, prescaler split of a tick, counter stepping
// with reload, read mux and the result registers.
// ----------------------------------------------------------------------------
module drtim_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  drtim_pkg::ctrl_cmd_t               cmd_i,
  output drtim_pkg::dp_sts_t                 sts_o,
  input  logic [drtim_pkg::CmdW-1:0]         item_cmd_i,
  input  logic [drtim_pkg::SelW-1:0]         item_sel_i,
  input  logic [drtim_pkg::ByteW-1:0]        item_data_i,
  input  logic [drtim_pkg::ByteW-1:0]        item_cycles_i,
  output logic [drtim_pkg::ByteW-1:0]        read_data_o,
  output logic                               overflow_o
);
  import drtim_pkg::*;

  // Architectural state.
  logic [DivW-1:0]  div_q;
  logic [PreW-1:0]  pre_q, pre_d;
  logic [ByteW-1:0] tima_q;
  logic [ByteW-1:0] tma_q;
  logic             en_q;
  logic [1:0]       rate_q;

  // Work state of the current item.
  logic [CntW-1:0]  cnt_q;
  logic [ByteW-1:0] res_rd_q, res_rd_d;
  logic             res_ovf_q;
  logic [ByteW-1:0] out_rd_q;
  logic             out_ovf_q;

  logic [AccW-1:0]  acc;
  logic [CntW-1:0]  per_cnt;
  logic [RoomW-1:0] room;
  logic             fits;
  logic             is_tick, is_read, is_write;

  assign is_tick  = (item_cmd_i == CMD_TICK);
  assign is_read  = (item_cmd_i == CMD_READ);
  assign is_write = (item_cmd_i == CMD_WRITE);

  // Split prescaler plus cycles into whole periods and the remainder.
  assign acc = {1'b0, pre_q} + {{(AccW-ByteW){1'b0}}, item_cycles_i};

  always_comb begin
    unique case (rate_q)
      RATE_16: begin
        per_cnt = acc[10:4];
        pre_d   = {6'b0, acc[3:0]};
      end
      RATE_64: begin
        per_cnt = {2'b0, acc[10:6]};
        pre_d   = {4'b0, acc[5:0]};
      end
      RATE_256: begin
        per_cnt = {4'b0, acc[10:8]};
        pre_d   = {2'b0, acc[7:0]};
      end
      default: begin
        per_cnt = {6'b0, acc[10]};
        pre_d   = acc[9:0];
      end
    endcase
  end

  // Read mux.
  always_comb begin
    res_rd_d = '0;
    if (is_read) begin
      unique case (item_sel_i)
        REG_DIV:  res_rd_d = div_q[DivW-1 -: ByteW];
        REG_TIMA: res_rd_d = tima_q;
        REG_TMA:  res_rd_d = tma_q;
        default:  res_rd_d = {5'b0, en_q, rate_q};
      endcase
    end
  end

  // Distance to the next overflow; one step consumes up to it.
  assign room = 9'd256 - {1'b0, tima_q};
  assign fits = ({2'b0, cnt_q} < room);

  // Timer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      pre_q  <= '0;
      tima_q <= '0;
      tma_q  <= '0;
      en_q   <= 1'b0;
      rate_q <= RATE_1024;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
      if (is_tick) begin
        div_q <= div_q + {{(DivW-ByteW){1'b0}}, item_cycles_i};
        if (en_q) begin
          pre_q <= pre_d;
          cnt_q <= per_cnt;
        end
      end else if (is_write) begin
        unique case (item_sel_i)
          REG_DIV:  div_q  <= '0;
          REG_TIMA: tima_q <= item_data_i;
          REG_TMA:  tma_q  <= item_data_i;
          default: begin
            en_q   <= item_data_i[TacEnBit];
            rate_q <= item_data_i[1:0];
          end
        endcase
      end
    end else if (cmd_i.step) begin
      if (fits) begin
        tima_q <= tima_q + {1'b0, cnt_q};
        cnt_q  <= '0;
      end else begin
        tima_q <= tma_q;
        cnt_q  <= cnt_q - room[CntW-1:0];
      end
    end
  end

  // Result being built and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_rd_q  <= res_rd_d;
      res_ovf_q <= 1'b0;
    end else if (cmd_i.step && !fits) begin
      res_ovf_q <= 1'b1;
    end
    if (cmd_i.push) begin
      out_rd_q  <= res_rd_q;
      out_ovf_q <= res_ovf_q;
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign read_data_o    = out_rd_q;
  assign overflow_o     = out_ovf_q;

  // Steps are only issued while periods remain.
  a_step_needs_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (cnt_q != '0))
    else $error("counter step with no periods left");

  // Items other than ticks leave no periods to consume.
  a_nontick_no_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && !is_tick) |=> (cnt_q == '0))
    else $error("non-tick item left periods pending");

  // A step that overflows reloads the counter from the modulo register.
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !fits) |=> (tima_q == $past(tma_q)))
    else $error("overflow did not reload the counter");

endmodule

/* hw/rtl/divider_and_reload_timer.sv */
// ----------------------------------------------------------------------------
// divider_and_reload_timer
// Divider, prescaler and reloading 8-bit counter driven by tick, read and
// write items; one result item per input item.
// ----------------------------------------------------------------------------
// Sequence: an item is accepted in the idle state; in the run state a tick
// that increments the counter takes counter steps, where a step ends at an
// overflow or applies the remaining increments (at most 79 steps), and then
// the result is pushed into the output register once that register is free.
// No new item is taken until the last result is pushed; output stalls hold it.
// Reset clears the timer state and control at once; no clearing pass.
// ----------------------------------------------------------------------------
module divider_and_reload_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  drtim_in_if.sink    in_i,
  drtim_out_if.source out_o
);
  import drtim_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // Control sequencing.
  drtim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  // Timer state and arithmetic.
  drtim_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .item_cmd_i    (in_i.cmd),
    .item_sel_i    (in_i.reg_select),
    .item_data_i   (in_i.write_data),
    .item_cycles_i (in_i.cycles),
    .read_data_o   (out_o.read_data),
    .overflow_o    (out_o.overflow)
  );

endmodule
